// File: design/tcw_pkg.sv
// Shared types and constants for the text console cell writer.
// Beat payloads, datapath mode codes, control/status structs and the cell builder.
// No dependencies.
package tcw_pkg;

  localparam int CURSOR_W = 11;

  // Operation codes carried in the func field
  localparam logic [1:0] FUNC_PUT  = 2'd0;
  localparam logic [1:0] FUNC_CLS  = 2'd1;
  localparam logic [1:0] FUNC_CLL  = 2'd2;
  localparam logic [1:0] FUNC_READ = 2'd3;

  // Character codes with special meaning
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_BLANK = 8'h20;

  // Configuration register indexes
  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [4:0]  line_index;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0]         cell_data;
    logic [CURSOR_W-1:0] cursor_pos;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SWEEP,
    MODE_PUT,
    MODE_TAB,
    MODE_ERASE,
    MODE_COPY,
    MODE_FILL,
    MODE_LINE
  } tcw_mode_t;

  typedef struct packed {
    tcw_mode_t mode;
    logic      accept;
    logic      load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic tab_end;
    logic copy_end;
    logic fill_end;
    logic line_end;
  } tcw_sts_t;

  function automatic logic [15:0] make_cell(input logic [3:0] fg, input logic [3:0] bg,
                                            input logic [7:0] ch);
    return {bg, fg, ch};
  endfunction

endpackage

// File: design/text_console_cell_writer_unit.sv
// Top level of the text console cell writer.
// Depends on tcw_pkg, tcw_ctrl, tcw_dpath (which holds tcw_ram).
//
// Usage
//   Input channel (in_valid / in_stall / in_data) carries one operation per beat:
//   put character, clear screen, clear line or read cell. Every beat yields exactly
//   one result beat on out_valid / out_stall / out_data: the cell read (zero for
//   other operations and for an out-of-range cell index) and the cursor after the operation.
//   cfg_we / cfg_index / cfg_data write the foreground (index 0) and background
//   (index 1) colour nibbles; write them only while the block is idle.
// Pacing, set by the single write port of the screen store: an ordinary character
//   writes one cell, erase blanks the cell before the cursor, tab writes TAB_SPACES
//   blanks, clear line writes one row, clear screen writes every cell, and newline /
//   carriage return copies rows 1 to ROWS-1 up by one row, then blanks the last row.
//   A new character is taken only after the previous one has been written.
// Reset: a clearing pass writes zero to all COLUMNS*ROWS cells; in_stall stays high
//   meanwhile, configuration writes still land.
// Stall: a finished result waits in the output register; the next beat is still
//   taken, and its result is held back until the receiver drops out_stall.
module text_console_cell_writer_unit #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  // sequencing and handshakes
  tcw_ctrl #(
    .ROWS (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // screen store, cursor, colours and result register
  tcw_dpath #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// File: design/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/tcw_ctrl.sv
// Controller of the text console cell writer: sequences each operation and owns
// the handshakes. Depends on tcw_pkg.
module tcw_ctrl #(
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcw_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PUT,
    ST_TAB,
    ST_ERASE,
    ST_COPY,
    ST_FILL,
    ST_LINE,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt, first_st;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, accept, load_out;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || (state_r == ST_DONE && out_free));
  assign accept   = in_valid && !in_stall;
  assign load_out = (state_r == ST_DONE) && out_free;

  // first working state of a freshly taken item
  always_comb begin
    first_st = ST_DONE;
    case (in_data.func)
      FUNC_PUT: begin
        case (in_data.char_code) inside
          CH_LF, CH_CR: first_st = ST_COPY;
          CH_TAB:       first_st = ST_TAB;
          CH_ESC:       first_st = ST_ERASE;
          default:      first_st = ST_PUT;
        endcase
      end
      FUNC_CLS: first_st = ST_FILL;
      FUNC_CLL: begin
        if (int'(in_data.line_index) < ROWS) begin
          first_st = ST_LINE;
        end
      end
      default: first_st = ST_DONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: if (sts.fill_end) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = first_st;
      ST_PUT:   state_nxt = ST_DONE;
      ST_ERASE: state_nxt = ST_DONE;
      ST_TAB:   if (sts.tab_end) state_nxt = ST_DONE;
      ST_COPY:  if (sts.copy_end) state_nxt = ST_FILL;
      ST_FILL:  if (sts.fill_end) state_nxt = ST_DONE;
      ST_LINE:  if (sts.line_end) state_nxt = ST_DONE;
      ST_DONE: begin
        if (accept) begin
          state_nxt = first_st;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd.accept   = accept;
    cmd.load_out = load_out;
    case (state_r)
      ST_SWEEP: cmd.mode = MODE_SWEEP;
      ST_PUT:   cmd.mode = MODE_PUT;
      ST_TAB:   cmd.mode = MODE_TAB;
      ST_ERASE: cmd.mode = MODE_ERASE;
      ST_COPY:  cmd.mode = MODE_COPY;
      ST_FILL:  cmd.mode = MODE_FILL;
      ST_LINE:  cmd.mode = MODE_LINE;
      default:  cmd.mode = MODE_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == ST_IDLE || state_r == ST_DONE))
    else $error("item taken while an operation is running");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> in_stall && !out_valid_r)
    else $error("traffic during the clearing pass");

endmodule

// File: design/tcw_dpath.sv
// Datapath of the text console cell writer: screen store, cursor, colour registers,
// sweep counter and result register. Depends on tcw_pkg and tcw_ram.
module tcw_dpath #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  input  tcw_pkg::tcw_cmd_t  cmd,
  output tcw_pkg::tcw_sts_t  sts,
  output tcw_pkg::out_item_t out_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LAST  = COLUMNS * (ROWS - 1);
  localparam int AW    = $clog2(CELLS + 1);
  localparam int RAW   = $clog2(CELLS);

  logic [AW-1:0]  cursor_r, cursor_nxt;
  logic [AW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  base_r;
  logic [3:0]     fg_r, bg_r;
  logic [1:0]     func_r;
  logic [7:0]     char_r;
  logic           idx_ok_r;
  out_item_t      out_r;

  logic           we, re, idx_ok;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata, rdata, blank;

  assign blank  = make_cell(fg_r, bg_r, CH_BLANK);
  assign idx_ok = int'(in_data.cell_index) < CELLS;

  always_comb begin
    we         = 1'b0;
    re         = 1'b0;
    waddr      = cnt_r;
    raddr      = cnt_r + AW'(COLUMNS);
    wdata      = 16'h0000;
    cnt_nxt    = cnt_r;
    cursor_nxt = cursor_r;
    case (cmd.mode)
      MODE_SWEEP: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      MODE_PUT, MODE_TAB: begin
        // drop the character once the cursor sits past the last cell
        if (cursor_r != AW'(CELLS)) begin
          we         = 1'b1;
          waddr      = cursor_r;
          wdata      = (cmd.mode == MODE_TAB) ? blank : make_cell(fg_r, bg_r, char_r);
          cursor_nxt = cursor_r + 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      MODE_ERASE: begin
        if (cursor_r != '0) begin
          we         = 1'b1;
          waddr      = cursor_r - 1'b1;
          wdata      = blank;
          cursor_nxt = cursor_r - 1'b1;
        end
      end
      MODE_COPY: begin
        // read one row ahead, write back the cell fetched last cycle
        re = (cnt_r != AW'(LAST));
        if (cnt_r != '0) begin
          we    = 1'b1;
          waddr = cnt_r - 1'b1;
          wdata = rdata;
        end
        cnt_nxt = (cnt_r == AW'(LAST)) ? cnt_r : cnt_r + 1'b1;
      end
      MODE_FILL: begin
        we         = 1'b1;
        wdata      = (func_r == FUNC_CLS && cnt_r < AW'(LAST)) ? {bg_r, fg_r, 8'h00} : blank;
        cnt_nxt    = cnt_r + 1'b1;
        cursor_nxt = AW'(LAST);
      end
      MODE_LINE: begin
        we      = 1'b1;
        waddr   = base_r + cnt_r;
        wdata   = {8'h00, CH_BLANK};
        cnt_nxt = cnt_r + 1'b1;
      end
      default: ;
    endcase
    if (cmd.accept) begin
      cnt_nxt = '0;
      if (in_data.func == FUNC_READ && idx_ok) begin
        re    = 1'b1;
        raddr = AW'(in_data.cell_index);
      end
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr[RAW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr[RAW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      cnt_r    <= '0;
      fg_r     <= 4'd7;
      bg_r     <= 4'd0;
    end else begin
      cursor_r <= cursor_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_FG) begin
          fg_r <= cfg_data;
        end else begin
          bg_r <= cfg_data;
        end
      end
    end
  end

  // item fields and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= in_data.func;
      char_r   <= in_data.char_code;
      idx_ok_r <= idx_ok;
      base_r   <= AW'(int'(in_data.line_index) * COLUMNS);
    end
    if (cmd.load_out) begin
      out_r.cell_data  <= (func_r == FUNC_READ && idx_ok_r) ? rdata : 16'h0000;
      out_r.cursor_pos <= CURSOR_W'(cursor_r);
    end
  end

  assign sts.tab_end  = (cnt_r == AW'(TAB_SPACES - 1));
  assign sts.copy_end = (cnt_r == AW'(LAST));
  assign sts.fill_end = (cnt_r == AW'(CELLS - 1));
  assign sts.line_end = (cnt_r == AW'(COLUMNS - 1));
  assign out_data     = out_r;

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= AW'(CELLS))
    else $error("cursor beyond end of screen");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mode == MODE_COPY |-> cnt_r <= AW'(LAST))
    else $error("scroll copy ran past the last source row");

  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> waddr < AW'(CELLS))
    else $error("write outside the screen store");

endmodule
